@@ src/i64a_pkg.sv @@
// Shared types and constants for the signed 64-bit to decimal ASCII formatter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package i64a_pkg;

  // Field and datapath widths
  localparam int unsigned ValueW    = 64;
  localparam int unsigned NumDigits = 20;
  localparam int unsigned BcdW      = NumDigits * 4;
  localparam int unsigned BitCntW   = $clog2(ValueW);
  localparam int unsigned DigCntW   = $clog2(NumDigits + 1);
  localparam int unsigned CharW     = 8;
  localparam int unsigned LenW      = 5;

  // Character codes
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;

  // Double-dabble correction
  localparam logic [3:0] DabbleLimit = 4'd5;
  localparam logic [3:0] DabbleAdd   = 4'd3;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_STRIP,
    S_SIGN,
    S_DIGIT
  } state_e;

  // Commands from the sequencer to the BCD shift datapath
  typedef struct packed {
    logic load;
    logic step;
    logic dshift;
  } dab_cmd_t;

  // One character leaving the sequencer
  typedef struct packed {
    logic             valid;
    logic [CharW-1:0] text_char;
    logic             is_last;
    logic [LenW-1:0]  text_length;
  } emit_t;

endpackage

@@ src/int64_to_decimal_ascii.sv @@
// Signed 64-bit to decimal ASCII: bit-serial double dabble over every magnitude bit, then a
// digit-serial strip of leading zeros, then one character per cycle.
// Busy from the accepting edge until the last character has been issued; the next
// item may start once busy is low. Results are not held off by the receiver.
// Reset (rst_ni low, asynchronous) returns to idle and clears the result strobe.
`timescale 1ns / 1ps

module int64_to_decimal_ascii (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [i64a_pkg::ValueW-1:0]    value_i,
  output logic                                  valid_o,
  output logic [i64a_pkg::CharW-1:0]            text_char_o,
  output logic                                  is_last_o,
  output logic [i64a_pkg::LenW-1:0]             text_length_o
);
  import i64a_pkg::*;

  dab_cmd_t         cmd;
  emit_t            emit;
  logic [3:0]       top_digit;
  logic             valid_q;
  logic [CharW-1:0] char_q;
  logic             last_q;
  logic [LenW-1:0]  len_q;

  // converter datapath
  i64a_dabble u_dabble (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .value_i     (value_i),
    .top_digit_o (top_digit)
  );

  // control
  i64a_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .neg_i       (value_i[ValueW-1]),
    .top_digit_i (top_digit),
    .cmd_o       (cmd),
    .emit_o      (emit)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= emit.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= emit.text_char;
    last_q <= emit.is_last;
    len_q  <= emit.text_length;
  end

  assign valid_o       = valid_q;
  assign text_char_o   = char_q;
  assign is_last_o     = last_q;
  assign text_length_o = len_q;

`ifndef SYNTHESIS
  // length of a text stays in range
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (text_length_o >= LenW'(1)) && (text_length_o <= LenW'(NumDigits)))
    else $error("text length out of range");

  // characters of one text are back to back
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !is_last_o |=> valid_o)
    else $error("gap inside a text");

  // last character is followed by a quiet cycle
  a_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && is_last_o |=> !valid_o)
    else $error("result after last character");

  // an accepted item makes the block busy
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accept");
`endif

endmodule

@@ src/i64a_dabble.sv @@
// Bit-serial binary to BCD converter (double dabble) with a digit shifter.
// Depends on i64a_pkg.
`timescale 1ns / 1ps

module i64a_dabble (
  input  logic                                   clk_i,
  input  i64a_pkg::dab_cmd_t                     cmd_i,
  input  logic signed [i64a_pkg::ValueW-1:0]     value_i,
  output logic [3:0]                             top_digit_o
);
  import i64a_pkg::*;

  logic [ValueW-1:0] mag_q, mag_d;
  logic [BcdW-1:0]   bcd_q, bcd_d;
  logic [BcdW-1:0]   adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= DabbleLimit) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + DabbleAdd;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // load magnitude, shift one bit in, or drop the top digit
  always_comb begin
    mag_d = mag_q;
    bcd_d = bcd_q;
    if (cmd_i.load) begin
      if (value_i[ValueW-1]) begin
        mag_d = (~value_i) + {{(ValueW-1){1'b0}}, 1'b1};
      end else begin
        mag_d = value_i;
      end
      bcd_d = '0;
    end else if (cmd_i.step) begin
      bcd_d = {adj[BcdW-2:0], mag_q[ValueW-1]};
      mag_d = {mag_q[ValueW-2:0], 1'b0};
    end else if (cmd_i.dshift) begin
      bcd_d = {bcd_q[BcdW-5:0], 4'b0000};
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
  end

  assign top_digit_o = bcd_q[BcdW-1 -: 4];

endmodule

@@ src/i64a_seq.sv @@
// Sequencer: conversion bit count, leading-zero strip, character emission.
// Depends on i64a_pkg.
`timescale 1ns / 1ps

module i64a_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               neg_i,
  input  logic [3:0]         top_digit_i,
  output i64a_pkg::dab_cmd_t cmd_o,
  output i64a_pkg::emit_t    emit_o
);
  import i64a_pkg::*;

  state_e             state_q, state_d;
  logic [BitCntW-1:0] bit_cnt_q, bit_cnt_d;
  logic [DigCntW-1:0] dig_cnt_q, dig_cnt_d;
  logic               neg_q, neg_d;
  logic [LenW-1:0]    len_q, len_d;
  logic               strip_more;
  logic               one_left;

  assign one_left   = (dig_cnt_q == DigCntW'(1));
  assign strip_more = (top_digit_i == 4'd0) && !one_left;
  assign busy       = (state_q != S_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) state_d = S_CONV;
      end
      S_CONV: begin
        if (bit_cnt_q == '0) state_d = S_STRIP;
      end
      S_STRIP: begin
        if (!strip_more) state_d = neg_q ? S_SIGN : S_DIGIT;
      end
      S_SIGN: begin
        state_d = S_DIGIT;
      end
      S_DIGIT: begin
        if (one_left) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs and counters
  always_comb begin
    cmd_o     = '0;
    emit_o    = '0;
    bit_cnt_d = bit_cnt_q;
    dig_cnt_d = dig_cnt_q;
    neg_d     = neg_q;
    len_d     = len_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          neg_d      = neg_i;
          bit_cnt_d  = BitCntW'(ValueW - 1);
        end
      end
      S_CONV: begin
        cmd_o.step = 1'b1;
        bit_cnt_d  = bit_cnt_q - 1'b1;
        if (bit_cnt_q == '0) dig_cnt_d = DigCntW'(NumDigits);
      end
      S_STRIP: begin
        if (strip_more) begin
          cmd_o.dshift = 1'b1;
          dig_cnt_d    = dig_cnt_q - 1'b1;
        end else begin
          len_d = LenW'(dig_cnt_q) + {{(LenW-1){1'b0}}, neg_q};
        end
      end
      S_SIGN: begin
        emit_o.valid       = 1'b1;
        emit_o.text_char   = CharMinus;
        emit_o.is_last     = 1'b0;
        emit_o.text_length = len_q;
      end
      S_DIGIT: begin
        emit_o.valid       = 1'b1;
        emit_o.text_char   = CharZero + {4'b0000, top_digit_i};
        emit_o.is_last     = one_left;
        emit_o.text_length = len_q;
        cmd_o.dshift       = 1'b1;
        dig_cnt_d          = dig_cnt_q - 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_cnt_q <= bit_cnt_d;
    dig_cnt_q <= dig_cnt_d;
    neg_q     <= neg_d;
    len_q     <= len_d;
  end

endmodule

@@ tb/tb_int64_to_decimal_ascii.sv @@
// Testbench for int64_to_decimal_ascii: drives signed 64-bit values and predicts their
// decimal text, then checks every emitted character, last flag and length in order.
// Depends on i64a_pkg and the int64_to_decimal_ascii top level only.
`timescale 1ns / 1ps

module tb_int64_to_decimal_ascii;
  import i64a_pkg::*;

  localparam int unsigned ClkHalf   = 5;
  localparam int unsigned DrainWait = 100;
  localparam logic [63:0] Radix     = 64'd10;
  localparam logic [63:0] MaxPos    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MinNeg    = 64'h8000_0000_0000_0000;

  // One expected character of the output text
  typedef struct packed {
    logic [CharW-1:0] text_char;
    logic             is_last;
    logic [LenW-1:0]  text_length;
  } text_char_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic signed [ValueW-1:0] value_i;
  logic                     valid_o;
  logic [CharW-1:0]         text_char_o;
  logic                     is_last_o;
  logic [LenW-1:0]          text_length_o;

  text_char_t text_expected[$];
  int         fault_count;

  int64_to_decimal_ascii u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .value_i       (value_i),
    .valid_o       (valid_o),
    .text_char_o   (text_char_o),
    .is_last_o     (is_last_o),
    .text_length_o (text_length_o)
  );

  // Clock
  initial clk_i = 1'b0;
  always #(ClkHalf) clk_i = ~clk_i;

  // Run limit
  initial begin
    #5_000_000;
    $display("FAIL int64_to_decimal_ascii");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Value with a given number of decimal digits (1 to 19), random sign
  function automatic logic [63:0] value_of_digits(input int unsigned digits);
    logic [63:0] lo;
    logic [63:0] span;
    logic [63:0] v;
    lo = 64'd1;
    for (int i = 1; i < digits; i++) lo = lo * Radix;
    span = (digits >= 19) ? (MaxPos - lo + 64'd1) : (lo * 64'd9);
    v = lo + (rand64() % span);
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // Decimal text of one value: sign first, then digits most significant first
  task automatic predict_text(input logic [63:0] v);
    logic [CharW-1:0] digit_buf[NumDigits];
    logic [63:0]      mag;
    logic             neg;
    int               ndig;
    int               len;
    int               pos;
    text_char_t       c;
    neg  = v[63];
    mag  = neg ? (~v + 64'd1) : v;
    ndig = 0;
    do begin
      digit_buf[ndig] = CharZero + CharW'(mag % Radix);
      ndig++;
      mag = mag / Radix;
    end while (mag != 64'd0);
    len = ndig + (neg ? 1 : 0);
    pos = 0;
    if (neg) begin
      c.text_char   = CharMinus;
      c.is_last     = (len == 1);
      c.text_length = LenW'(len);
      text_expected.push_back(c);
      pos = 1;
    end
    for (int k = ndig - 1; k >= 0; k--) begin
      c.text_char   = digit_buf[k];
      c.is_last     = (pos == len - 1);
      c.text_length = LenW'(len);
      text_expected.push_back(c);
      pos++;
    end
  endtask

  // Offer one item and hold it until the block takes it; start is left high
  task automatic send_value(input logic [63:0] v);
    start   <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy);
    predict_text(v);
  endtask

  // Sender drops start and idles, optionally only once the block has gone idle
  task automatic idle_burst(input bit after_busy);
    int n;
    n = $urandom_range(1, 7);
    start <= 1'b0;
    if (after_busy) begin
      value_i <= rand64();
      @(posedge clk_i);
      while (busy) begin
        value_i <= rand64();
        @(posedge clk_i);
      end
    end
    repeat (n) begin
      value_i <= rand64();
      @(posedge clk_i);
    end
  endtask

  // Sender holds off until all outstanding text has come out
  task automatic drain_text();
    start <= 1'b0;
    while (text_expected.size() != 0) @(posedge clk_i);
  endtask

  // Random idling between items, sometimes landing after the block has finished
  task automatic maybe_idle();
    if ($urandom_range(0, 2) == 0) idle_burst($urandom_range(0, 1) == 1);
  endtask

  // Extremes, zero, single digits, digit-count boundaries, alternating bits
  task automatic test_directed();
    logic [63:0] vals[$];
    vals = '{64'd0, 64'd1, -64'sd1, 64'd9, -64'sd9, 64'd10, -64'sd10, 64'd99, 64'd100,
             MaxPos, MinNeg, MinNeg + 64'd1, 64'd1_000_000_000_000_000_000,
             64'd999_999_999_999_999_999, -64'sd1_000_000_000_000_000_000,
             64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'd12345,
             64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000};
    foreach (vals[i]) send_value(vals[i]);
    drain_text();
  endtask

  // Values of every text length, with idling on the sender side
  task automatic test_random_lengths();
    repeat (130) begin
      send_value(value_of_digits($urandom_range(1, 19)));
      maybe_idle();
    end
  endtask

  // Full random bit patterns, with a full hold-off partway through
  task automatic test_random_patterns();
    for (int i = 0; i < 60; i++) begin
      send_value(rand64());
      if (i == 30) drain_text();
      else maybe_idle();
    end
  endtask

  // Back to back items with no idling at all
  task automatic test_back_to_back();
    repeat (50) begin
      if ($urandom_range(0, 1) == 1) send_value(value_of_digits($urandom_range(1, 19)));
      else send_value(rand64());
    end
  endtask

  // Result checker: each character against the oldest expectation
  always @(posedge clk_i) begin : check_text
    text_char_t exp_c;
    if (rst_ni && valid_o) begin
      if (text_expected.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual %h last %b len %0d",
                 $time, text_char_o, is_last_o, text_length_o);
        fault_count++;
      end else begin
        exp_c = text_expected.pop_front();
        if (text_char_o !== exp_c.text_char) begin
          $display("%0t: text_char mismatch: expected %h, actual %h",
                   $time, exp_c.text_char, text_char_o);
          fault_count++;
        end
        if (is_last_o !== exp_c.is_last) begin
          $display("%0t: is_last mismatch: expected %b, actual %b",
                   $time, exp_c.is_last, is_last_o);
          fault_count++;
        end
        if (text_length_o !== exp_c.text_length) begin
          $display("%0t: text_length mismatch: expected %0d, actual %0d",
                   $time, exp_c.text_length, text_length_o);
          fault_count++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    fault_count = 0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    value_i     = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_lengths();
    test_random_patterns();
    test_back_to_back();

    drain_text();
    repeat (DrainWait) @(posedge clk_i);
    if (fault_count == 0 && text_expected.size() == 0) begin
      $display("PASS int64_to_decimal_ascii");
    end else begin
      $display("FAIL int64_to_decimal_ascii");
    end
    $finish;
  end

endmodule
